>>> sv/exdf_pkg.sv
`timescale 1ns / 1ps

package exdf_pkg;

  localparam logic [7:0] VEC_DOUBLE_FAULT = 8'd8;
  localparam logic [7:0] VEC_PAGE_FAULT   = 8'd14;
  localparam logic [7:0] VEC_DIVIDE_ERROR = 8'd0;
  localparam logic [7:0] VEC_INVALID_TSS  = 8'd10;
  localparam logic [7:0] VEC_SEG_NP       = 8'd11;
  localparam logic [7:0] VEC_STACK_FAULT  = 8'd12;
  localparam logic [7:0] VEC_GP_FAULT     = 8'd13;

  localparam logic OP_RAISE  = 1'b0;
  localparam logic OP_RETIRE = 1'b1;

  typedef enum logic [1:0] {
    CLASS_BENIGN,
    CLASS_CONTRIB,
    CLASS_PAGE
  } vec_class_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  vector;
    logic        code_valid;
    logic [31:0] fault_code;
    logic        payload_valid;
    logic [63:0] payload;
    logic        reinject;
    logic        protected_mode;
    logic        guest_mode;
  } item_t;

  typedef struct packed {
    logic        pending;
    logic        injected;
    logic [7:0]  vector;
    logic        code_valid;
    logic [31:0] fault_code;
    logic        payload_valid;
    logic [63:0] payload;
  } slot_t;

  typedef struct packed {
    logic        triple_fault;
    logic        double_fault;
    slot_t       slot;
    logic [63:0] payload_shown;
    logic        deliver_payload;
  } result_t;

  function automatic vec_class_t vec_class(input logic [7:0] v);
    vec_class_t c;
    c = CLASS_BENIGN;
    if (v == VEC_PAGE_FAULT) begin
      c = CLASS_PAGE;
    end else if (v == VEC_DIVIDE_ERROR || v == VEC_INVALID_TSS || v == VEC_SEG_NP ||
                 v == VEC_STACK_FAULT || v == VEC_GP_FAULT) begin
      c = CLASS_CONTRIB;
    end
    return c;
  endfunction

endpackage

>>> sv/exdf_in_stage.sv
`timescale 1ns / 1ps

module exdf_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  exdf_pkg::item_t item_in,
  input  logic           take,
  output logic           item_valid,
  output exdf_pkg::item_t item_out
);
  import exdf_pkg::*;

  logic  valid_r;
  item_t item_r;
  logic  load;

  assign load     = in_valid && (!valid_r || take);
  assign in_stall = valid_r && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  assign item_valid = valid_r;
  assign item_out   = item_r;

endmodule

>>> sv/exdf_slot.sv
`timescale 1ns / 1ps

module exdf_slot (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              step,
  input  exdf_pkg::item_t   item,
  output exdf_pkg::result_t result
);
  import exdf_pkg::*;

  logic       payload_defer_enable;
  slot_t      slot_r;
  slot_t      slot_next;
  vec_class_t held_class;
  vec_class_t new_class;
  logic       fill;
  logic       promote;
  logic       triple;
  logic       deliver;
  logic       herr_eff;
  logic       hpay_eff;
  logic [63:0] pay_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_defer_enable <= 1'b0;
    end else if (cfg_we) begin
      payload_defer_enable <= cfg_wdata;
    end
  end

  assign held_class = vec_class(slot_r.vector);
  assign new_class  = vec_class(item.vector);
  assign herr_eff   = item.code_valid && item.protected_mode;
  assign hpay_eff   = item.reinject ? 1'b0 : item.payload_valid;
  assign pay_eff    = item.reinject ? 64'd0 : item.payload;

  always_comb begin
    slot_next = slot_r;
    fill      = 1'b0;
    promote   = 1'b0;
    triple    = 1'b0;
    deliver   = 1'b0;
    if (item.operation == OP_RETIRE) begin
      slot_next = '0;
    end else if (!slot_r.pending && !slot_r.injected) begin
      fill = 1'b1;
    end else if (slot_r.vector == VEC_DOUBLE_FAULT) begin
      triple = 1'b1;
    end else if ((held_class == CLASS_CONTRIB && new_class == CLASS_CONTRIB) ||
                 (held_class == CLASS_PAGE && new_class != CLASS_BENIGN)) begin
      promote                 = 1'b1;
      slot_next.pending       = 1'b1;
      slot_next.injected      = 1'b0;
      slot_next.vector        = VEC_DOUBLE_FAULT;
      slot_next.code_valid    = 1'b1;
      slot_next.fault_code    = 32'd0;
      slot_next.payload_valid = 1'b0;
      slot_next.payload       = 64'd0;
    end else begin
      fill = 1'b1;
    end

    if (fill) begin
      if (item.reinject) begin
        slot_next.injected = 1'b1;
      end else begin
        slot_next.pending  = 1'b1;
        slot_next.injected = 1'b0;
      end
      slot_next.vector        = item.vector;
      slot_next.code_valid    = herr_eff;
      slot_next.fault_code    = item.fault_code;
      slot_next.payload_valid = hpay_eff;
      slot_next.payload       = pay_eff;
      if ((!payload_defer_enable || !item.guest_mode) && hpay_eff) begin
        deliver                 = 1'b1;
        slot_next.payload_valid = 1'b0;
        slot_next.payload       = 64'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_r <= '0;
    end else if (step) begin
      slot_r <= slot_next;
    end
  end

  assign result.triple_fault    = triple;
  assign result.double_fault    = promote;
  assign result.slot            = slot_next;
  assign result.payload_shown   = deliver ? pay_eff : slot_next.payload;
  assign result.deliver_payload = deliver;

  a_retire_empties: assert property (@(posedge clk) disable iff (rst)
    step && item.operation == OP_RETIRE |=> !slot_r.pending && !slot_r.injected)
    else $error("slot not empty after retire");

  a_triple_holds: assert property (@(posedge clk) disable iff (rst)
    step && triple |=> $stable(slot_r))
    else $error("slot changed on triple fault");

  a_promote_form: assert property (@(posedge clk) disable iff (rst)
    step && promote |=> slot_r.pending && !slot_r.injected &&
      slot_r.vector == VEC_DOUBLE_FAULT && slot_r.fault_code == 32'd0)
    else $error("bad double fault promotion");

  a_deliver_clears: assert property (@(posedge clk) disable iff (rst)
    step && deliver |=> !slot_r.payload_valid && slot_r.payload == 64'd0)
    else $error("payload kept after delivery");

endmodule

>>> sv/exdf_out_stage.sv
`timescale 1ns / 1ps

module exdf_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  exdf_pkg::result_t result_in,
  output logic              take,
  output logic              out_valid,
  input  logic              out_stall,
  output exdf_pkg::result_t result_out
);
  import exdf_pkg::*;

  logic    valid_r;
  result_t result_r;

  assign take = !valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result_in;
    end
  end

  assign out_valid  = valid_r;
  assign result_out = result_r;

endmodule

>>> sv/exception_merge_double_fault.sv
`timescale 1ns / 1ps

// Single x86 exception slot with double-fault promotion. Each transaction either raises an
// exception into the slot (fill, replace, promote to vector 8, or flag a triple fault) or
// retires it, and returns one result showing the slot after the update plus any payload
// handed out. One transaction is taken every cycle unless a stalled result holds it back;
// out_valid rises once an accepted transaction has passed the input register and then the
// merge logic into the result register. A stalled result holds the input register, and once
// that is full in_stall follows out_stall in the same cycle. The slot state register updates
// on each step, so back-to-back raises see each other. The user must write payload_defer_enable
// through cfg_we/cfg_wdata only while no transaction is in flight; the block does not check.
module exception_merge_double_fault (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  vector,
  input  logic        code_valid,
  input  logic [31:0] fault_code,
  input  logic        payload_valid,
  input  logic [63:0] payload,
  input  logic        reinject,
  input  logic        protected_mode,
  input  logic        guest_mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        triple_fault,
  output logic        double_fault,
  output logic        pending_out,
  output logic        injected_out,
  output logic [7:0]  vector_out,
  output logic        code_valid_out,
  output logic [31:0] fault_code_out,
  output logic        payload_valid_out,
  output logic [63:0] payload_out,
  output logic        deliver_payload
);
  import exdf_pkg::*;

  item_t   item_in;
  item_t   item_q;
  logic    item_valid;
  logic    take;
  logic    step;
  result_t result_d;
  result_t result_q;

  assign item_in.operation      = operation;
  assign item_in.vector         = vector;
  assign item_in.code_valid     = code_valid;
  assign item_in.fault_code     = fault_code;
  assign item_in.payload_valid  = payload_valid;
  assign item_in.payload        = payload;
  assign item_in.reinject       = reinject;
  assign item_in.protected_mode = protected_mode;
  assign item_in.guest_mode     = guest_mode;

  assign step = item_valid && take;

  exdf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .item_in    (item_in),
    .take       (take),
    .item_valid (item_valid),
    .item_out   (item_q)
  );

  exdf_slot u_slot (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item_q),
    .result    (result_d)
  );

  exdf_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .result_in  (result_d),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .result_out (result_q)
  );

  assign triple_fault      = result_q.triple_fault;
  assign double_fault      = result_q.double_fault;
  assign pending_out       = result_q.slot.pending;
  assign injected_out      = result_q.slot.injected;
  assign vector_out        = result_q.slot.vector;
  assign code_valid_out    = result_q.slot.code_valid;
  assign fault_code_out    = result_q.slot.fault_code;
  assign payload_valid_out = result_q.slot.payload_valid;
  assign payload_out       = result_q.payload_shown;
  assign deliver_payload   = result_q.deliver_payload;

endmodule
